/* rtl/sv39m_pkg.sv */
// Sv39 page table mapper: shared types and constants.
// No dependencies.
package sv39m_pkg;

    localparam int PPN_W  = 44;
    localparam int VA_W   = 39;
    localparam int PA_W   = 56;
    localparam int CNT_W  = 16;
    localparam int PTE_W  = 64;
    localparam int IDX_W  = 9;
    localparam logic [7:0] LEAF_FLAGS = 8'hCF;

    typedef enum logic [1:0] {
        CMD_MAP       = 2'd0,
        CMD_ALLOC     = 2'd1,
        CMD_RESERVE   = 2'd2,
        CMD_TRANSLATE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MAPPED    = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_OUTSIDE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_POOL_BASE  = 2'd0,
        REG_POOL_PAGES = 2'd1,
        REG_ROOT       = 2'd2,
        REG_FREE_START = 2'd3
    } reg_idx_t;

endpackage

/* rtl/sv39_page_table_mapper.sv */
// Sv39 page table mapper. Tables are kept in a single synchronous page-pool
// memory; one walker state machine serves all four commands.
//
// Usage:
//   Request channel (req_valid/req_ready) carries cmd, virt_addr, phys_addr
//   and page_count. Response channel (rsp_valid/rsp_ready) carries status,
//   result_addr and pages_done; exactly one response per request. The user
//   must write the registers over APB only while idle; this is not enforced.
// Walk: each table level passes through a check, a read and an evaluate
//   state, paced by the single read/write port of the table memory. A full
//   three-level walk (map, alloc, translate) raises rsp_valid when its
//   result loads into the response register, as the walker returns to idle.
//   Early exits: a root outside the pool stops at the first check, and a
//   reserve of no pages goes straight to done. A reserve walks once per page.
// One request is worked on at a time; a new one is taken when the walker is
//   idle, even while the previous response still waits in its register.
// Reset: after rst_n is released the memory is cleared one entry a cycle,
//   POOL_PAGES*512 entries (32768 by default); requests wait until done.
// A stalled response holds; the walker accepts one more request and then
//   waits with its result until the response register frees.
module sv39_page_table_mapper #(
    parameter int POOL_PAGES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  cmd,
    input  logic [38:0] virt_addr,
    input  logic [55:0] phys_addr,
    input  logic [15:0] page_count,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  status,
    output logic [55:0] result_addr,
    output logic [15:0] pages_done
);
    import sv39m_pkg::*;

    localparam int PG_W    = $clog2(POOL_PAGES);
    localparam int DEPTH   = POOL_PAGES * 512;
    localparam int ADDR_W  = PG_W + IDX_W;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_CHK   = 10'b0000000100,
        S_RD    = 10'b0000001000,
        S_EVAL  = 10'b0000010000,
        S_LRD   = 10'b0000100000,
        S_LEVAL = 10'b0001000000,
        S_NEXT  = 10'b0010000000,
        S_DONE  = 10'b0100000000,
        S_WAIT  = 10'b1000000000
    } state_t;

    // ---------------- registers ----------------
    state_t              state_reg;
    logic [PPN_W-1:0]    pool_base_reg, root_reg, free_start_reg, next_free_reg;
    logic [6:0]          pool_pages_reg;
    logic [1:0]          cmd_reg;
    logic [VA_W-1:0]     va_reg;
    logic [PPN_W-1:0]    pa_ppn_reg;
    logic [CNT_W-1:0]    cnt_reg, done_reg;
    logic [1:0]          lvl_reg;
    logic [PPN_W-1:0]    tbl_reg;
    logic [PG_W-1:0]     off_reg;
    logic [ADDR_W-1:0]   clr_reg;
    logic [1:0]          st_reg;
    logic [PA_W-1:0]     res_reg;
    logic                rsp_valid_reg;
    logic [1:0]          rsp_status_reg;
    logic [PA_W-1:0]     rsp_addr_reg;
    logic [CNT_W-1:0]    rsp_done_reg;

    // ---------------- memory ----------------
    logic [PTE_W-1:0]    mem [DEPTH];
    logic [PTE_W-1:0]    rd_data;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_addr;
    logic [PTE_W-1:0]    mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data <= mem[mem_addr];
    end

    // ---------------- config port ----------------
    logic cfg_wr;
    logic [1:0] cfg_idx;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        case (cfg_idx)
            REG_POOL_BASE:  prdata = {20'd0, pool_base_reg};
            REG_POOL_PAGES: prdata = {57'd0, pool_pages_reg};
            REG_ROOT:       prdata = {20'd0, root_reg};
            REG_FREE_START: prdata = {20'd0, free_start_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------- pool membership ----------------
    logic [12:0] lim;
    assign lim = (13'(pool_pages_reg) < 13'(POOL_PAGES)) ? 13'(pool_pages_reg)
                                                         : 13'(POOL_PAGES);

    function automatic logic in_pool(input logic [PPN_W-1:0] p,
                                     input logic [PPN_W-1:0] base,
                                     input logic [12:0] l);
        logic [PPN_W-1:0] d;
        d = p - base;
        return d < PPN_W'(l);
    endfunction

    logic [PPN_W-1:0] tbl_off;
    logic tbl_in, free_in;
    assign tbl_off  = tbl_reg - pool_base_reg;
    assign tbl_in   = in_pool(tbl_reg, pool_base_reg, lim);
    assign free_in  = in_pool(next_free_reg, pool_base_reg, lim);

    logic [IDX_W-1:0] lvl_idx, leaf_idx;
    assign lvl_idx  = (lvl_reg == 2'd0) ? va_reg[38:30] : va_reg[29:21];
    assign leaf_idx = va_reg[20:12];

    logic create;
    assign create = (cmd_reg != CMD_TRANSLATE);

    // response register loads when the walker is finished and the slot is free
    logic rsp_load;
    assign rsp_load = ((state_reg == S_DONE) || (state_reg == S_WAIT))
                      && (!rsp_valid_reg || rsp_ready);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign status = rsp_status_reg;
    assign result_addr = rsp_addr_reg;
    assign pages_done = rsp_done_reg;

    // memory address/write
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        mem_addr  = {off_reg, lvl_idx};
        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
            end
            S_RD:    mem_addr = {off_reg, lvl_idx};
            S_EVAL:
            begin
                mem_addr  = {off_reg, lvl_idx};
                mem_wdata = {10'd0, next_free_reg, 10'd1};
                mem_we    = !rd_data[0] && create && free_in;
            end
            S_LRD:   mem_addr = {off_reg, leaf_idx};
            S_LEVAL:
            begin
                mem_addr = {off_reg, leaf_idx};
                if (!rd_data[0] && cmd_reg == CMD_MAP)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {10'd0, pa_ppn_reg, 2'b00, LEAF_FLAGS};
                end
                else if (!rd_data[0] && cmd_reg == CMD_ALLOC && free_in)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {10'd0, next_free_reg, 2'b00, LEAF_FLAGS};
                end
            end
            default: ;
        endcase
    end

    // ---------------- walker ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            pool_base_reg  <= '0;
            pool_pages_reg <= 7'd64;
            root_reg       <= '0;
            free_start_reg <= 44'd1;
            next_free_reg  <= 44'd1;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_POOL_BASE:  pool_base_reg  <= pwdata[PPN_W-1:0];
                    REG_POOL_PAGES: pool_pages_reg <= pwdata[6:0];
                    REG_ROOT:       root_reg       <= pwdata[PPN_W-1:0];
                    REG_FREE_START:
                    begin
                        free_start_reg <= pwdata[PPN_W-1:0];
                        next_free_reg  <= pwdata[PPN_W-1:0];
                    end
                    default: ;
                endcase
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ADDR_W'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        cmd_reg    <= cmd;
                        va_reg     <= virt_addr;
                        pa_ppn_reg <= phys_addr[55:12];
                        cnt_reg    <= page_count;
                        done_reg   <= '0;
                        st_reg     <= ST_OK;
                        res_reg    <= '0;
                        lvl_reg    <= 2'd0;
                        tbl_reg    <= root_reg;
                        if (cmd == CMD_RESERVE && page_count == '0)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    off_reg <= tbl_off[PG_W-1:0];
                    if (!tbl_in)
                    begin
                        st_reg    <= ST_OUTSIDE;
                        state_reg <= S_DONE;
                    end
                    else if (lvl_reg == 2'd2)
                        state_reg <= S_LRD;
                    else
                        state_reg <= S_RD;
                end
                S_RD: state_reg <= S_EVAL;
                S_EVAL:
                begin
                    lvl_reg <= lvl_reg + 2'd1;
                    if (rd_data[0])
                    begin
                        tbl_reg   <= rd_data[53:10];
                        state_reg <= S_CHK;
                    end
                    else if (!create)
                        state_reg <= S_DONE;
                    else if (!free_in)
                    begin
                        st_reg    <= ST_EXHAUSTED;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        tbl_reg       <= next_free_reg;
                        next_free_reg <= next_free_reg + 1'b1;
                        state_reg     <= S_CHK;
                    end
                end
                S_LRD: state_reg <= (cmd_reg == CMD_RESERVE) ? S_NEXT : S_LEVAL;
                S_LEVAL:
                begin
                    state_reg <= S_DONE;
                    case (cmd_reg)
                        CMD_TRANSLATE: res_reg <= {rd_data[53:10], 12'd0};
                        CMD_MAP: if (rd_data[0]) st_reg <= ST_MAPPED;
                        CMD_ALLOC:
                        begin
                            if (rd_data[0])
                            begin
                                st_reg  <= ST_MAPPED;
                                res_reg <= {17'd0, va_reg[38:12], 12'd0};
                            end
                            else if (!free_in)
                                st_reg <= ST_EXHAUSTED;
                            else
                            begin
                                res_reg       <= {next_free_reg, 12'd0};
                                next_free_reg <= next_free_reg + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_NEXT:
                begin
                    done_reg <= done_reg + 1'b1;
                    va_reg   <= va_reg + 39'h1000;
                    lvl_reg  <= 2'd0;
                    tbl_reg  <= root_reg;
                    if (done_reg + 1'b1 == cnt_reg)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_CHK;
                end
                S_DONE, S_WAIT:
                begin
                    if (rsp_load)
                    begin
                        rsp_status_reg <= st_reg;
                        rsp_addr_reg   <= res_reg;
                        rsp_done_reg   <= done_reg;
                        state_reg      <= S_IDLE;
                    end
                    else
                        state_reg <= S_WAIT;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // Checks on walker behaviour
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req_ready)
        else $error("request taken while busy");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |=> (rsp_valid_reg && $stable(rsp_addr_reg)))
        else $error("response dropped while stalled");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("table write while idle");
`endif
endmodule
